@@ hdl/url_fixed_string_matcher_macros.svh @@
// Assertion helpers used by the matcher RTL.
`ifndef URL_FIXED_STRING_MATCHER_MACROS_SVH
`define URL_FIXED_STRING_MATCHER_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define UFSM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ufsm assertion failed");

// Next-cycle implication, quiet during reset.
`define UFSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ufsm assertion failed");

`endif

@@ hdl/ufsm_pkg.sv @@
`timescale 1ns / 1ps
package ufsm_pkg;

   typedef enum logic [2:0] {
      CSR_PATTERN_LENGTH = 3'd0,
      CSR_MATCH_MODE     = 3'd1,
      CSR_CASE_SENSITIVE = 3'd2,
      CSR_PATTERN_WORD_0 = 3'd3,
      CSR_PATTERN_WORD_1 = 3'd4,
      CSR_PATTERN_WORD_2 = 3'd5,
      CSR_PATTERN_WORD_3 = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_ANYWHERE = 2'd0,
      MODE_START    = 2'd1,
      MODE_END      = 2'd2,
      MODE_NEVER    = 2'd3
   } mode_type;

   localparam int          CSR_INDEX_W  = 3;
   localparam int          CSR_DATA_W   = 64;
   localparam int          LENGTH_W     = 6;
   localparam logic [7:0]  ASCII_UPPER_A = 8'h41;
   localparam logic [7:0]  ASCII_UPPER_Z = 8'h5A;
   localparam logic [7:0]  CASE_OFFSET   = 8'h20;
   localparam logic [LENGTH_W-1:0] SEEN_MAX = '1;

   typedef struct packed {
      logic advance;
      logic clear;
   } cell_ctrl_type;

endpackage

@@ hdl/ufsm_cell.sv @@
`timescale 1ns / 1ps
module ufsm_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  ufsm_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]              data_byte,
   input  logic [7:0]              pattern_byte,
   input  logic                    prev_match,
   output logic                    match_in,
   output logic                    match_ff
);
   import ufsm_pkg::*;

   // prefix of one more byte ends here if the shorter prefix ended one byte ago
   assign match_in = prev_match && (data_byte == pattern_byte);

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         match_ff <= 1'b0;
      end else if (ctrl.advance) begin
         match_ff <= match_in;
      end
   end

endmodule

@@ hdl/ufsm_out_stage.sv @@
`timescale 1ns / 1ps
module ufsm_out_stage (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic push_matched,
   input  logic rsp_stall,
   output logic rsp_valid,
   output logic rsp_matched,
   output logic full
);
   logic out_valid_ff;
   logic out_matched_ff;
   logic skid_valid_ff;
   logic skid_matched_ff;
   logic out_free;

   assign out_free    = !out_valid_ff || !rsp_stall;
   assign rsp_valid   = out_valid_ff;
   assign rsp_matched = out_matched_ff;
   assign full        = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         // drain the skid first; no push can arrive while it is full
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_matched_ff <= skid_valid_ff ? skid_matched_ff : push_matched;
      end
      if (!out_free && push) begin
         skid_matched_ff <= push_matched;
      end
   end

endmodule

@@ hdl/url_fixed_string_matcher.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    req_url_byte[7:0], req_final_byte
// rsp_      out        rsp_valid/stall    rsp_matched
// csr_      in         csr_write          csr_index[2:0], csr_wdata[63:0]
//
// One URL byte is taken every cycle while req_stall is low; a row of MAX_PATTERN
// match cells compares every pattern prefix against the incoming byte in parallel.
// After its final byte, a URL's answer is registered in the output stage or the skid.
// Synchronous reset clears the cells, counters and the output and skid stages.
// A stalled result parks in a one-entry skid; req_stall rises only while it is full.
`include "url_fixed_string_matcher_macros.svh"
module url_fixed_string_matcher #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_url_byte,
   input  logic                                req_final_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_matched,
   input  logic                                csr_write,
   input  logic [ufsm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ufsm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ufsm_pkg::*;

   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam logic [LENGTH_W-1:0] MAX_LEN = LENGTH_W'(MAX_PATTERN);

   logic [LENGTH_W-1:0] pattern_length_ff;
   mode_type            match_mode_ff;
   logic                case_sensitive_ff;
   logic [7:0]          pat_ff [MAX_PATTERN];

   logic [LENGTH_W-1:0] seen_ff;
   logic [LENGTH_W-1:0] seen_in;
   logic                found_ff;
   logic                found_in;
   logic                start_ok_ff;
   logic                start_ok_in;

   logic                req_accept;
   logic                last_accept;
   logic [7:0]          url_fold;
   logic [LENGTH_W-1:0] len_eff;
   logic                win;
   logic                hit;
   logic                out_full;
   cell_ctrl_type       cell_ctrl;

   logic [MAX_PATTERN-1:0] chain_in;
   logic [MAX_PATTERN-1:0] match_next;
   logic [MAX_PATTERN-1:0] match_state;

   assign req_stall   = out_full;
   assign req_accept  = req_valid && !req_stall;
   assign last_accept = req_accept && req_final_byte;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         match_mode_ff     <= MODE_ANYWHERE;
         case_sensitive_ff <= 1'b1;
         for (int k = 0; k < MAX_PATTERN; k++) begin
            pat_ff[k] <= 8'h00;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[LENGTH_W-1:0];
            CSR_MATCH_MODE:     match_mode_ff     <= mode_type'(csr_wdata[1:0]);
            CSR_CASE_SENSITIVE: case_sensitive_ff <= csr_wdata[0];
            CSR_PATTERN_WORD_0, CSR_PATTERN_WORD_1,
            CSR_PATTERN_WORD_2, CSR_PATTERN_WORD_3: begin
               for (int k = 0; k < MAX_PATTERN; k++) begin
                  if (csr_index == CSR_INDEX_W'((k >> 3) + 3)) begin
                     pat_ff[k] <= csr_wdata[8*(k & 7) +: 8];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign url_fold = (!case_sensitive_ff && req_url_byte >= ASCII_UPPER_A &&
                      req_url_byte <= ASCII_UPPER_Z) ? req_url_byte + CASE_OFFSET
                                                     : req_url_byte;
   assign len_eff  = (pattern_length_ff > MAX_LEN) ? MAX_LEN : pattern_length_ff;

   assign cell_ctrl.advance = req_accept;
   assign cell_ctrl.clear   = last_accept;

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      if (j == 0) begin : g_head
         assign chain_in[j] = 1'b1;
      end else begin : g_link
         assign chain_in[j] = match_state[j-1];
      end
      ufsm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .data_byte    (url_fold),
         .pattern_byte (pat_ff[j]),
         .prev_match   (chain_in[j]),
         .match_in     (match_next[j]),
         .match_ff     (match_state[j])
      );
   end

   // whole pattern ends at this byte
   assign win = (len_eff == '0) ? 1'b1 : match_next[IDX_W'(len_eff - 1'b1)];

   always_comb begin
      seen_in     = (seen_ff == SEEN_MAX) ? SEEN_MAX : seen_ff + 1'b1;
      found_in    = found_ff || win;
      start_ok_in = start_ok_ff;
      if (seen_ff < len_eff && pat_ff[IDX_W'(seen_ff)] != url_fold) begin
         start_ok_in = 1'b0;
      end
      unique case (match_mode_ff)
         MODE_ANYWHERE: hit = found_in;
         MODE_START:    hit = (seen_in >= len_eff) && start_ok_in;
         MODE_END:      hit = win;
         MODE_NEVER:    hit = 1'b0;
         default:       hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || last_accept) begin
         seen_ff     <= '0;
         found_ff    <= 1'b0;
         start_ok_ff <= 1'b1;
      end else if (req_accept) begin
         seen_ff     <= seen_in;
         found_ff    <= found_in;
         start_ok_ff <= start_ok_in;
      end
   end

   ufsm_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .push         (last_accept),
      .push_matched (hit),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_matched  (rsp_matched),
      .full         (out_full)
   );

   `UFSM_ASSERT_IMPL(a_skid_behind_out, clock, reset, out_full, rsp_valid)
   `UFSM_ASSERT_NEXT(a_clear_after_last, clock, reset, last_accept, seen_ff == '0 && !found_ff && start_ok_ff && match_state == '0)
   `UFSM_ASSERT_IMPL(a_cells_need_bytes, clock, reset, match_state != '0, seen_ff != '0)

endmodule
